// ===== sv/assert_macros.svh =====
// Assertion macros shared by the value list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vlist_pkg.sv =====
// Package: field widths, command and status codes, parameter defaults for the value list.
package vlist_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 5;
  localparam int LIMIT_W   = 5;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

endpackage

// ===== sv/vlist_if.sv =====
// Channel interfaces of the value list: command input, result output, configuration write.
interface vlist_in_if
  import vlist_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface vlist_out_if
  import vlist_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                found;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;
  logic                is_full;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output found, output count, output is_empty,
                  output is_full, output status, input ready);
  modport sink   (input valid, input found, input count, input is_empty,
                  input is_full, input status, output ready);
endinterface

interface vlist_cfg_if
  import vlist_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/vlist_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vlist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/value_list_insert_delete_search.sv =====
// Value list: up to DEPTH data words kept packed in arrival order in one RAM, with
// append, delete-first-match, search and clear commands, one result per command.
// Append and clear act on accept and then offer their result from the FINISH state.
// Search walks the held entries through the RAM's single read port, one entry a cycle.
// Delete walks to the first match and then moves each later entry down one place, one
// entry a cycle over the same read port with overlapped writes.
// in_ch.ready is high only between commands; the next command can be taken in the
// cycle the result is first offered, and a finished result may wait in the output
// register while that command runs. The capacity limit (cfg_ch) acts as 1 when
// written 0 and as DEPTH when above DEPTH; write it only while the block is idle.
// The RAM has no reset and no clearing pass: only positions below the count are read.
`include "assert_macros.svh"

module value_list_insert_delete_search
  import vlist_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  vlist_in_if.sink    in_ch,
  vlist_out_if.source out_ch,
  vlist_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         wptr_r, wptr_nxt;
  logic                  pend_r, pend_nxt;
  logic [LIMIT_W-1:0]    limit_r, limit_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  hit_r, hit_nxt;
  status_t               stat_r, stat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_full_r, out_full_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  logic [VALUE_W+DATA_WIDTH-1:0] val_ext;
  logic [DATA_WIDTH-1:0]         val_in;
  logic [CW+COUNT_W-1:0]         cnt_ext;
  logic [LW-1:0]                 lim_e, eff_lim, cnt_e;
  logic                          full;
  logic                          in_acc;

  // Keep the low DATA_WIDTH bits of the word, zero-extended when wider than the field.
  assign val_ext = {{DATA_WIDTH{1'b0}}, in_ch.value};
  assign val_in  = val_ext[DATA_WIDTH-1:0];
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  // Clamp the limit into 1..DEPTH.
  assign lim_e = LW'(limit_r);
  always_comb begin
    if (lim_e == '0) begin
      eff_lim = LW'(1);
    end else if (lim_e > LW'(DEPTH)) begin
      eff_lim = LW'(DEPTH);
    end else begin
      eff_lim = lim_e;
    end
  end
  assign cnt_e = LW'(cnt_r);
  assign full  = (cnt_e >= eff_lim);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    wptr_nxt       = wptr_r;
    pend_nxt       = pend_r;
    limit_nxt      = limit_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    hit_nxt        = hit_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    out_status_nxt = out_status_r;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = val_in;
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];

    if (cfg_ch.valid) begin
      limit_nxt = cfg_ch.data;
    end

    // Drop the result once its beat is taken.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = cmd_t'(in_ch.command);
          val_nxt  = val_in;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          hit_nxt  = 1'b0;
          stat_nxt = ST_DONE;
          case (cmd_t'(in_ch.command))
            CMD_APPEND: begin
              if (full) begin
                stat_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                cnt_nxt = cnt_r + CW'(1);
              end
              state_nxt = S_FINISH;
            end
            CMD_DELETE, CMD_SEARCH: begin
              state_nxt = S_SCAN;
            end
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (pend_r && (rd_data == val_r)) begin
          hit_nxt  = 1'b1;
          pend_nxt = 1'b0;
          if (cmd_r == CMD_DELETE) begin
            wptr_nxt  = idx_r - CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (idx_r < cnt_r) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (cmd_r == CMD_DELETE) begin
            stat_nxt = ST_ABSENT;
          end
          state_nxt = S_FINISH;
        end
      end

      S_SHIFT: begin
        // Write the entry read last cycle one place down while reading the next.
        if (pend_r) begin
          wr_en    = 1'b1;
          wr_addr  = wptr_r[AW-1:0];
          wr_data  = rd_data;
          wptr_nxt = wptr_r + CW'(1);
        end
        if (idx_r < cnt_r) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = hit_r;
          out_count_nxt  = cnt_ext[COUNT_W-1:0];
          out_empty_nxt  = (cnt_r == '0);
          out_full_nxt   = full;
          out_status_nxt = stat_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    wptr_r       <= wptr_nxt;
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    hit_r        <= hit_nxt;
    stat_r       <= stat_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
    out_status_r <= out_status_nxt;
  end

  vlist_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.count    = out_count_r;
  assign out_ch.is_empty = out_empty_r;
  assign out_ch.is_full  = out_full_r;
  assign out_ch.status   = out_status_r;

  `VL_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "count beyond depth")
  `VL_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ch.ready, "ready while a command runs")
  `VL_ASSERT_SAME(a_shift_below_cnt, wr_en && (state_r == S_SHIFT), wptr_r < cnt_r, "bad shift")
  `VL_ASSERT_SAME(a_absent_no_hit, out_valid_r && (out_status_r == ST_ABSENT), !out_found_r, "absent with found set")

endmodule

// ===== tb/sv/tb_value_list_insert_delete_search.sv =====
// Self-checking testbench for the value list: directed table, then random phases per limit.
`timescale 1ns / 100ps

module tb_value_list_insert_delete_search
  import vlist_pkg::*;
;
  localparam int LIST_DEPTH      = DEPTH_DEF;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int STALL_LIMIT     = 5000;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_PHASE      = 4;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
    status_t            status;
  } list_result_t;

  typedef struct {
    bit           is_cfg;
    cmd_t         cmd;
    logic [31:0]  value;
    bit           typed;
    list_result_t res;
  } dir_row_t;

  localparam list_result_t NO_RES = '0;
  localparam int NUM_ROWS = 25;

  // Value doubles as the limit on configuration rows.
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{1'b0, CMD_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b0, ST_DONE}},
    '{1'b0, CMD_DELETE, 32'h0000_0000, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b0, ST_ABSENT}},
    '{1'b0, CMD_CLEAR,  32'h0000_0000, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b0, ST_DONE}},
    '{1'b0, CMD_APPEND, 32'h0000_0000, 1'b1, '{1'b0, 5'd1, 1'b0, 1'b0, ST_DONE}},
    '{1'b0, CMD_APPEND, 32'hFFFF_FFFF, 1'b1, '{1'b0, 5'd2, 1'b0, 1'b0, ST_DONE}},
    '{1'b0, CMD_SEARCH, 32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd2, 1'b0, 1'b0, ST_DONE}},
    '{1'b0, CMD_SEARCH, 32'h8000_0000, 1'b1, '{1'b0, 5'd2, 1'b0, 1'b0, ST_DONE}},
    '{1'b0, CMD_DELETE, 32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd1, 1'b0, 1'b0, ST_DONE}},
    '{1'b0, CMD_DELETE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 5'd1, 1'b0, 1'b0, ST_ABSENT}},
    '{1'b0, CMD_APPEND, 32'hA5A5_A5A5, 1'b0, NO_RES},
    '{1'b0, CMD_APPEND, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b0, CMD_APPEND, 32'h5A5A_5A5A, 1'b0, NO_RES},
    '{1'b0, CMD_DELETE, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b0, CMD_SEARCH, 32'h0000_0000, 1'b0, NO_RES},
    '{1'b1, CMD_APPEND, 32'd2,         1'b0, NO_RES},
    '{1'b0, CMD_APPEND, 32'h0000_0001, 1'b1, '{1'b0, 5'd3, 1'b0, 1'b1, ST_FULL}},
    '{1'b0, CMD_SEARCH, 32'h5A5A_5A5A, 1'b0, NO_RES},
    '{1'b0, CMD_DELETE, 32'hA5A5_A5A5, 1'b0, NO_RES},
    '{1'b1, CMD_APPEND, 32'd0,         1'b0, NO_RES},
    '{1'b0, CMD_CLEAR,  32'h1234_5678, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b0, ST_DONE}},
    '{1'b0, CMD_APPEND, 32'h0000_0007, 1'b1, '{1'b0, 5'd1, 1'b0, 1'b1, ST_DONE}},
    '{1'b0, CMD_APPEND, 32'h0000_0008, 1'b1, '{1'b0, 5'd1, 1'b0, 1'b1, ST_FULL}},
    '{1'b1, CMD_APPEND, 32'd31,        1'b0, NO_RES},
    '{1'b0, CMD_APPEND, 32'h0000_0008, 1'b1, '{1'b0, 5'd2, 1'b0, 1'b0, ST_DONE}},
    '{1'b0, CMD_CLEAR,  32'hFFFF_FFFF, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b0, ST_DONE}}
  };

  logic [LIMIT_W-1:0] phase_limits [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd31, 5'd4, 5'd17, 5'd0, 5'd12, 5'd2, 5'd16
  };

  logic clk = 1'b0;
  logic rst_n;

  vlist_in_if  in_ch ();
  vlist_out_if out_ch ();
  vlist_cfg_if cfg_ch ();

  value_list_insert_delete_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted list contents and limit.
  logic [31:0]        list_words [LIST_DEPTH];
  int                 list_len  = 0;
  logic [LIMIT_W-1:0] cap_limit = LIMIT_RESET;

  list_result_t pending_results [$];
  list_result_t in_typed_res;
  bit           in_typed;

  int cmds_accepted   = 0;
  int results_checked = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;
  int tx_idle_pct     = 0;
  int rx_idle_pct     = 0;
  bit rx_hold_req     = 1'b0;

  function automatic list_result_t list_apply(cmd_t c, logic [31:0] v);
    list_result_t r;
    int lim;
    int pos;
    r = '0;
    r.status = ST_DONE;
    lim = (cap_limit == 0) ? 1 : ((cap_limit > LIST_DEPTH) ? LIST_DEPTH : int'(cap_limit));
    pos = list_len;
    for (int i = list_len - 1; i >= 0; i--)
      if (list_words[i] == v) pos = i;
    case (c)
      CMD_APPEND: begin
        if (list_len >= lim) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = v;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (pos < list_len) begin
          r.found = 1'b1;
          // shift later entries down over the match
          for (int i = pos; i < list_len - 1; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      CMD_SEARCH: r.found = (pos < list_len);
      default:    list_len = 0;
    endcase
    r.count    = COUNT_W'(list_len);
    r.is_empty = (list_len == 0);
    r.is_full  = (list_len >= lim);
    return r;
  endfunction

  // Monitor: retire results first, then predict the command taken at this edge.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.found    = out_ch.found;
        got.count    = out_ch.count;
        got.is_empty = out_ch.is_empty;
        got.is_full  = out_ch.is_full;
        got.status   = status_t'(out_ch.status);
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            fail_count++;
          end
          if (got.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          results_checked++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) cap_limit = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        want = list_apply(cmd_t'(in_ch.command), in_ch.value);
        pending_results.push_back(in_typed ? in_typed_res : want);
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_cmd(cmd_t c, logic [31:0] v, bit typed, list_result_t typed_res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= c;
    in_ch.value   <= v;
    in_typed      <= typed;
    in_typed_res  <= typed_res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cmds_accepted++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (results_checked != cmds_accepted) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= lim;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] value_pool [8];
    logic [31:0] v;
    cmd_t        c;
    int          mix;
    int          r;
    int          app_lim;
    int          del_lim;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_APPEND;
    in_ch.value   <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= LIMIT_RESET;
    in_typed      <= 1'b0;
    in_typed_res  <= NO_RES;
    tx_idle_pct    = 32;
    rx_idle_pct   <= 52;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_for_results();
        write_limit(dir_rows[i].value[LIMIT_W-1:0]);
      end else begin
        offer_cmd(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      write_limit(phase_limits[p]);
      if (p < 3) begin
        tx_idle_pct  = 32;
        rx_idle_pct <= 52;
      end else if (p < 6) begin
        tx_idle_pct  = 52;
        rx_idle_pct <= 32;
      end else begin
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
      end
      // stall the receiver while commands keep coming
      if (p == HOLD_PHASE) rx_hold_req <= ~rx_hold_req;

      // small pool so deletes and searches mostly hit
      foreach (value_pool[k]) value_pool[k] = $urandom;
      value_pool[0] = $urandom_range(3);
      value_pool[1] = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;

      mix = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 40 == 0) mix = $urandom_range(2);
        case (mix)
          0:       begin app_lim = 65; del_lim = 80; end
          1:       begin app_lim = 20; del_lim = 70; end
          default: begin app_lim = 40; del_lim = 68; end
        endcase
        r = $urandom_range(99);
        if (r >= 98)          c = CMD_CLEAR;
        else if (r < app_lim) c = CMD_APPEND;
        else if (r < del_lim) c = CMD_DELETE;
        else                  c = CMD_SEARCH;
        v = ($urandom_range(4) == 0) ? 32'($urandom) : value_pool[$urandom_range(7)];
        offer_cmd(c, v, 1'b0, NO_RES);
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
